>>> hdl/dwc_pkg.sv
// Shared constants, types and command/status structs for the depthwise 1D convolution.
`default_nettype none
package dwc_pkg;

    localparam int MAX_CHANNELS = 64;
    localparam int MAX_TAPS     = 16;
    localparam int MAX_ROW      = 4096;
    localparam int DATA_BITS    = 16;

    localparam int CH_BITS   = $clog2(MAX_CHANNELS);
    localparam int TAP_BITS  = $clog2(MAX_TAPS);
    localparam int POS_BITS  = $clog2(MAX_ROW);
    localparam int ADDR_BITS = CH_BITS + TAP_BITS;
    localparam int DEPTH     = MAX_CHANNELS * MAX_TAPS;

    localparam int NCH_BITS   = 7;
    localparam int K_BITS     = 5;
    localparam int RW_BITS    = 13;
    localparam int SH_BITS    = 5;
    localparam int CFG_BITS   = 13;
    localparam int CFG_A_BITS = 2;
    localparam int MAX_SHIFT  = 30;

    localparam int PROD_BITS = 2 * DATA_BITS;
    localparam int ACC_BITS  = PROD_BITS + TAP_BITS;
    localparam int RND_BITS  = ACC_BITS + 1;

    localparam logic [CFG_A_BITS-1:0] CFG_CHANNELS = 2'd0;
    localparam logic [CFG_A_BITS-1:0] CFG_KERNEL   = 2'd1;
    localparam logic [CFG_A_BITS-1:0] CFG_ROW      = 2'd2;
    localparam logic [CFG_A_BITS-1:0] CFG_SHIFT    = 2'd3;

    localparam logic MODE_LOAD   = 1'b0;
    localparam logic MODE_SAMPLE = 1'b1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_RUN,
        S_DRAIN1,
        S_DRAIN2,
        S_ROUND,
        S_OUT
    } t_state;

    typedef struct packed {
        logic [NCH_BITS-1:0] nch;
        logic [K_BITS-1:0]   k;
        logic [RW_BITS-1:0]  rw;
        logic [SH_BITS-1:0]  sh;
    } t_cfg;

    typedef struct packed {
        logic                load_coef;
        logic                start;
        logic                issue;
        logic [TAP_BITS-1:0] step;
        logic                round;
        logic                finish;
    } t_cmd;

    typedef struct packed {
        logic emit;
        logic out_free;
    } t_status;

endpackage
`default_nettype wire

>>> hdl/depthwise_conv1d.sv
// Top level of the depthwise 1D valid convolution: config registers, controller, datapath.
// Sample items are taken one at a time: the next is accepted only after the 16-step tap
// walk over the shared multiplier, pipeline drain, rounding and any output load of the
// last. Load items are written straight into the coefficient store while idle.
// A result waiting at the output blocks new items only once the next result is ready
// to load.
// Reset (synchronous, active low) clears counters, control and output valid; both stores
// are undefined until written.
`default_nettype none
module depthwise_conv1d
    import dwc_pkg::*;
(
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    // config write port
    input  wire logic                   i_cfg_we,
    input  wire logic [CFG_A_BITS-1:0]  i_cfg_addr,
    input  wire logic [CFG_BITS-1:0]    i_cfg_wdata,
    // input stream
    input  wire logic                   i_s_tvalid,
    output logic                        o_s_tready,
    input  wire logic [31:0]            i_s_tdata,  // coef_channel[5:0], coef_tap[9:6], value[25:10]
    input  wire logic                   i_s_tuser,  // mode
    // result stream
    output logic                        o_m_tvalid,
    input  wire logic                   i_m_tready,
    output logic [39:0]                 o_m_tdata,  // out_value[15:0], out_channel[21:16],
                                                    // out_position[33:22]
    output logic                        o_m_tlast,  // row_end
    output logic                        o_m_tuser   // saturated
);

    // raw register values as written
    logic [NCH_BITS-1:0] r_nch;
    logic [K_BITS-1:0]   r_k;
    logic [RW_BITS-1:0]  r_rw;
    logic [SH_BITS-1:0]  r_sh;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_nch <= NCH_BITS'(1);
            r_k   <= K_BITS'(1);
            r_rw  <= RW_BITS'(1);
            r_sh  <= SH_BITS'(14);
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                CFG_CHANNELS: r_nch <= i_cfg_wdata[NCH_BITS-1:0];
                CFG_KERNEL:   r_k   <= i_cfg_wdata[K_BITS-1:0];
                CFG_ROW:      r_rw  <= i_cfg_wdata[RW_BITS-1:0];
                CFG_SHIFT:    r_sh  <= i_cfg_wdata[SH_BITS-1:0];
                default: ;
            endcase
        end
    end

    // zero channels, kernel or row width act as one; oversize values clip to the store limits (shift to MAX_SHIFT)
    t_cfg cfg;
    always_comb begin
        cfg.nch = (r_nch == '0) ? NCH_BITS'(1) :
                  (r_nch > NCH_BITS'(MAX_CHANNELS)) ? NCH_BITS'(MAX_CHANNELS) : r_nch;
        cfg.k   = (r_k == '0) ? K_BITS'(1) :
                  (r_k > K_BITS'(MAX_TAPS)) ? K_BITS'(MAX_TAPS) : r_k;
        cfg.rw  = (r_rw == '0) ? RW_BITS'(1) :
                  (r_rw > RW_BITS'(MAX_ROW)) ? RW_BITS'(MAX_ROW) : r_rw;
        cfg.sh  = (r_sh > SH_BITS'(MAX_SHIFT)) ? SH_BITS'(MAX_SHIFT) : r_sh;
    end

    t_cmd    cmd;
    t_status sts;

    dwc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .i_s_mode   (i_s_tuser),
        .i_sts      (sts),
        .o_s_tready (o_s_tready),
        .o_cmd      (cmd)
    );

    logic [DATA_BITS-1:0] out_value;
    logic [CH_BITS-1:0]   out_channel;
    logic [POS_BITS-1:0]  out_position;

    dwc_datapath u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg          (cfg),
        .i_cmd          (cmd),
        .i_coef_channel (i_s_tdata[5:0]),
        .i_coef_tap     (i_s_tdata[9:6]),
        .i_value        (i_s_tdata[25:10]),
        .i_m_tready     (i_m_tready),
        .o_valid        (o_m_tvalid),
        .o_out_value    (out_value),
        .o_out_channel  (out_channel),
        .o_out_position (out_position),
        .o_row_end      (o_m_tlast),
        .o_saturated    (o_m_tuser),
        .o_sts          (sts)
    );

    // result fields packed from bit 0, padded to whole bytes
    assign o_m_tdata = {6'd0, out_position, out_channel, out_value};

endmodule
`default_nettype wire

>>> hdl/dwc_ctrl.sv
// Sequencer for the depthwise convolution: accepts items, walks the taps, drains and rounds.
`default_nettype none
module dwc_ctrl
    import dwc_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_s_tvalid,
    input  wire logic    i_s_mode,
    input  wire t_status i_sts,
    output logic         o_s_tready,
    output t_cmd         o_cmd
);

    t_state              r_state, n_state;
    logic [TAP_BITS-1:0] r_step,  n_step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_step     = r_step;
        o_s_tready = 1'b0;
        o_cmd      = '0;
        o_cmd.step = r_step;
        case (r_state)
            S_IDLE: begin
                o_s_tready = 1'b1;
                if (i_s_tvalid) begin
                    if (i_s_mode == MODE_LOAD) begin
                        o_cmd.load_coef = 1'b1;
                    end else begin
                        o_cmd.start = 1'b1;
                        n_step      = TAP_BITS'(MAX_TAPS - 1);
                        n_state     = S_RUN;
                    end
                end
            end
            S_RUN: begin
                o_cmd.issue = 1'b1;
                n_step      = r_step - 1'b1;
                if (r_step == '0) begin
                    n_state = S_DRAIN1;
                end
            end
            S_DRAIN1: begin
                n_state = S_DRAIN2;
            end
            S_DRAIN2: begin
                n_state = S_ROUND;
            end
            S_ROUND: begin
                o_cmd.round = 1'b1;
                n_state     = S_OUT;
            end
            S_OUT: begin
                if (!i_sts.emit) begin
                    n_state = S_IDLE;
                end else if (i_sts.out_free) begin
                    o_cmd.finish = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    a_finish_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.finish |-> (i_sts.out_free && i_sts.emit))
        else $error("result loaded while output register still held");

    a_start_runs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.start |=> (r_state == S_RUN && r_step == TAP_BITS'(MAX_TAPS - 1)))
        else $error("sample accepted without starting the tap walk");

    a_run_exit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RUN && n_state == S_DRAIN1) |-> (r_step == '0))
        else $error("tap walk ended early");

    a_round_then_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.round |=> (r_state == S_OUT))
        else $error("rounding not followed by output stage");

endmodule
`default_nettype wire

>>> hdl/dwc_datapath.sv
// Datapath: coefficient and history stores, counters, multiply-accumulate, round and saturate.
`default_nettype none
module dwc_datapath
    import dwc_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire t_cfg                  i_cfg,
    input  wire t_cmd                  i_cmd,
    input  wire logic [CH_BITS-1:0]    i_coef_channel,
    input  wire logic [TAP_BITS-1:0]   i_coef_tap,
    input  wire logic [DATA_BITS-1:0]  i_value,
    input  wire logic                  i_m_tready,
    output logic                       o_valid,
    output logic [DATA_BITS-1:0]       o_out_value,
    output logic [CH_BITS-1:0]         o_out_channel,
    output logic [POS_BITS-1:0]        o_out_position,
    output logic                       o_row_end,
    output logic                       o_saturated,
    output t_status                    o_sts
);

    logic signed [DATA_BITS-1:0] mem_coef [0:DEPTH-1];
    logic signed [DATA_BITS-1:0] mem_hist [0:DEPTH-1];

    // row/channel counters
    logic [CH_BITS-1:0]  r_cnt_ch;
    logic [POS_BITS-1:0] r_cnt_pos;

    // per-item context
    logic [CH_BITS-1:0]          r_ch;
    logic [POS_BITS-1:0]         r_opos;
    logic                        r_rowend;
    logic                        r_emit;
    logic signed [DATA_BITS-1:0] r_sample;

    // pipeline
    logic signed [DATA_BITS-1:0] r_coef_rd, r_hist_rd;
    logic                        r_b_valid, r_b_tap;
    logic [TAP_BITS-1:0]         r_b_step;
    logic signed [PROD_BITS-1:0] r_prod;
    logic                        r_c_valid;
    logic signed [ACC_BITS-1:0]  r_acc;
    logic signed [RND_BITS-1:0]  r_rnd;

    logic                        r_out_valid;
    logic [DATA_BITS-1:0]        r_out_value;
    logic [CH_BITS-1:0]          r_out_ch;
    logic [POS_BITS-1:0]         r_out_pos;
    logic                        r_out_last, r_out_sat;

    // counter clamping
    logic [CH_BITS-1:0]  ch_eff;
    logic [POS_BITS-1:0] pos_eff;
    logic                last_ch, last_pos;
    logic [RW_BITS-1:0]  pos_p1;
    logic [NCH_BITS-1:0] nch_m1;
    logic [RW_BITS-1:0]  rw_m1;

    always_comb begin
        nch_m1   = i_cfg.nch - 1'b1;
        rw_m1    = i_cfg.rw - 1'b1;
        ch_eff   = ({1'b0, r_cnt_ch} >= i_cfg.nch) ? nch_m1[CH_BITS-1:0] : r_cnt_ch;
        pos_eff  = ({1'b0, r_cnt_pos} >= i_cfg.rw) ? rw_m1[POS_BITS-1:0] : r_cnt_pos;
        last_ch  = ({1'b0, ch_eff} == nch_m1);
        last_pos = ({1'b0, pos_eff} == rw_m1);
        pos_p1   = {1'b0, pos_eff} + 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt_ch  <= '0;
            r_cnt_pos <= '0;
        end else if (i_cmd.start) begin
            if (last_ch) begin
                r_cnt_ch  <= '0;
                r_cnt_pos <= last_pos ? '0 : pos_p1[POS_BITS-1:0];
            end else begin
                r_cnt_ch  <= ch_eff + 1'b1;
                r_cnt_pos <= pos_eff;
            end
        end
    end

    logic [RW_BITS-1:0] opos_full;
    assign opos_full = pos_p1 - RW_BITS'(i_cfg.k);

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_ch     <= ch_eff;
            r_opos   <= opos_full[POS_BITS-1:0];
            r_rowend <= last_ch && last_pos;
            r_emit   <= (pos_p1 >= RW_BITS'(i_cfg.k));
            r_sample <= i_value;
        end
    end

    // coefficient store: written on load items, read during the tap walk
    logic [K_BITS-1:0] tap_full;
    logic              tap_ok;
    assign tap_full = i_cfg.k - 1'b1 - K_BITS'(i_cmd.step);
    assign tap_ok   = (K_BITS'(i_cmd.step) < i_cfg.k);

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_coef) begin
            mem_coef[{i_coef_channel, i_coef_tap}] <= i_value;
        end
        if (i_cmd.issue) begin
            r_coef_rd <= mem_coef[{r_ch, tap_full[TAP_BITS-1:0]}];
            r_hist_rd <= mem_hist[{r_ch, i_cmd.step - 1'b1}];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
            r_c_valid <= 1'b0;
        end else begin
            r_b_valid <= i_cmd.issue;
            r_c_valid <= r_b_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.issue) begin
            r_b_step <= i_cmd.step;
            r_b_tap  <= tap_ok;
        end
    end

    // stage B: shift history entry up by one, multiply with its tap
    logic signed [DATA_BITS-1:0] d_b;
    assign d_b = (r_b_step == '0) ? r_sample : r_hist_rd;

    always_ff @(posedge i_clk) begin
        if (r_b_valid) begin
            mem_hist[{r_ch, r_b_step}] <= d_b;
            r_prod <= r_b_tap ? (r_coef_rd * d_b) : PROD_BITS'(0);
        end
    end

    // stage C: accumulate
    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_acc <= '0;
        end else if (r_c_valid) begin
            r_acc <= r_acc + ACC_BITS'(r_prod);
        end
    end

    // rounding bias, half up
    logic signed [RND_BITS-1:0] bias;
    always_comb begin
        bias = '0;
        if (i_cfg.sh != '0) begin
            bias = RND_BITS'(1) << (i_cfg.sh - 1'b1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.round) begin
            r_rnd <= RND_BITS'(r_acc) + bias;
        end
    end

    // shift and saturate
    logic signed [RND_BITS-1:0]    shifted;
    logic [RND_BITS-DATA_BITS:0]   top_bits;
    logic                          sat;
    logic [DATA_BITS-1:0]          clipped;

    always_comb begin
        shifted  = r_rnd >>> i_cfg.sh;
        top_bits = shifted[RND_BITS-1:DATA_BITS-1];
        sat      = !((&top_bits) || (~|top_bits));
        if (!sat) begin
            clipped = shifted[DATA_BITS-1:0];
        end else if (shifted[RND_BITS-1]) begin
            clipped = {1'b1, {(DATA_BITS-1){1'b0}}};
        end else begin
            clipped = {1'b0, {(DATA_BITS-1){1'b1}}};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.finish) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            r_out_value <= clipped;
            r_out_ch    <= r_ch;
            r_out_pos   <= r_opos;
            r_out_last  <= r_rowend;
            r_out_sat   <= sat;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_out_value    = r_out_value;
    assign o_out_channel  = r_out_ch;
    assign o_out_position = r_out_pos;
    assign o_row_end      = r_out_last;
    assign o_saturated    = r_out_sat;

    assign o_sts.emit     = r_emit;
    assign o_sts.out_free = !r_out_valid || i_m_tready;

endmodule
`default_nettype wire

>>> verif/tb_depthwise_conv1d.sv
// Self-checking testbench for depthwise_conv1d: stream stimulus, scoreboard and final verdict.
module tb_depthwise_conv1d;
    timeunit 1ns;
    timeprecision 1ps;

    import dwc_pkg::*;

    localparam int SETTLE_CYCLES   = 40;    // wait before any reg write, longer than the block takes for one sample
    localparam int HOLD_CYCLES     = 400;   // long receiver hold-off to back the block up
    localparam int WATCHDOG_CYCLES = 5000;  // cycles with no handshake before we give up
    localparam int RANDOM_ITEMS    = 1100;

    // one result item as it leaves the block
    typedef struct packed {
        logic signed [DATA_BITS-1:0] value;
        logic [CH_BITS-1:0]          channel;
        logic [POS_BITS-1:0]         position;
        logic                        row_end;
        logic                        saturated;
    } t_conv_result;

    // Tracks taps, per-channel history and row counters; computes the result each
    // accepted sample causes and holds it until the block delivers it.
    class conv_scoreboard;
        logic [NCH_BITS-1:0]         nch_reg;
        logic [K_BITS-1:0]           k_reg;
        logic [RW_BITS-1:0]          rw_reg;
        logic [SH_BITS-1:0]          sh_reg;
        logic signed [DATA_BITS-1:0] taps [MAX_CHANNELS][MAX_TAPS];
        bit                          tap_loaded [MAX_CHANNELS][MAX_TAPS];
        logic signed [DATA_BITS-1:0] history [MAX_CHANNELS][MAX_TAPS];
        int unsigned                 ch_cnt;
        int unsigned                 pos_cnt;
        t_conv_result                awaited [$];
        int                          errors;

        function new();
            nch_reg = 1;
            k_reg   = 1;
            rw_reg  = 1;
            sh_reg  = 14;
            ch_cnt  = 0;
            pos_cnt = 0;
            errors  = 0;
            foreach (taps[c, t]) begin
                taps[c][t]       = '0;
                history[c][t]    = '0;
                tap_loaded[c][t] = 1'b0;
            end
        endfunction

        // zero acts as one, anything above the hardware maximum saturates
        function int unsigned clamp(int unsigned raw, int unsigned hi);
            if (raw == 0) return 1;
            if (raw > hi) return hi;
            return raw;
        endfunction

        function int unsigned live_channels();
            return clamp(nch_reg, MAX_CHANNELS);
        endfunction

        function int unsigned live_taps();
            return clamp(k_reg, MAX_TAPS);
        endfunction

        function void set_reg(logic [CFG_A_BITS-1:0] idx, logic [CFG_BITS-1:0] word);
            case (idx)
                CFG_CHANNELS: nch_reg = word[NCH_BITS-1:0];
                CFG_KERNEL:   k_reg   = word[K_BITS-1:0];
                CFG_ROW:      rw_reg  = word[RW_BITS-1:0];
                CFG_SHIFT:    sh_reg  = word[SH_BITS-1:0];
                default: ;
            endcase
        endfunction

        task report(string what, longint got, longint want);
            errors++;
            $display("mismatch %s: got %0d, expected %0d", what, got, want);
        endtask

        function void note_item(logic mode, logic [CH_BITS-1:0] cch,
                                logic [TAP_BITS-1:0] ctap, logic signed [DATA_BITS-1:0] val);
            int unsigned  nch, k, rw, sh, ch, pos, i;
            longint       acc;
            t_conv_result res;
            if (mode == MODE_LOAD) begin
                taps[cch][ctap]       = val;
                tap_loaded[cch][ctap] = 1'b1;
                return;
            end
            nch = live_channels();
            k   = live_taps();
            rw  = clamp(rw_reg, MAX_ROW);
            sh  = (sh_reg > MAX_SHIFT) ? MAX_SHIFT : sh_reg;
            // counters left past a shrunken limit act as the last value
            ch  = (ch_cnt >= nch) ? nch - 1 : ch_cnt;
            pos = (pos_cnt >= rw) ? rw - 1 : pos_cnt;
            for (i = MAX_TAPS - 1; i > 0; i--) history[ch][i] = history[ch][i-1];
            history[ch][0] = val;
            if (ch == nch - 1) begin
                ch_cnt  = 0;
                pos_cnt = (pos == rw - 1) ? 0 : pos + 1;
            end else begin
                ch_cnt  = ch + 1;
                pos_cnt = pos;
            end
            if (pos + 1 < k) return;   // window not full yet
            acc = 0;
            for (i = 0; i < k; i++)
                acc += longint'(taps[ch][i]) * longint'(history[ch][k-1-i]);
            if (sh > 0) acc += longint'(1) << (sh - 1);
            acc = acc >>> sh;
            res.saturated = 1'b0;
            if (acc > 32767) begin
                acc = 32767;
                res.saturated = 1'b1;
            end else if (acc < -32768) begin
                acc = -32768;
                res.saturated = 1'b1;
            end
            res.value    = acc[DATA_BITS-1:0];
            res.channel  = ch[CH_BITS-1:0];
            res.position = POS_BITS'(pos + 1 - k);
            res.row_end  = (ch == nch - 1) && (pos == rw - 1);
            awaited.push_back(res);
        endfunction

        task check_result(logic signed [DATA_BITS-1:0] v, logic [CH_BITS-1:0] c,
                          logic [POS_BITS-1:0] p, logic last, logic sat);
            t_conv_result want;
            if (awaited.size() == 0) begin
                report("result with none pending, out_value", v, 0);
                return;
            end
            want = awaited.pop_front();
            if (v !== want.value)        report("out_value", v, want.value);
            if (c !== want.channel)      report("out_channel", c, want.channel);
            if (p !== want.position)     report("out_position", p, want.position);
            if (last !== want.row_end)   report("row_end", last, want.row_end);
            if (sat !== want.saturated)  report("saturated", sat, want.saturated);
        endtask
    endclass

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_A_BITS-1:0] cfg_addr;
    logic [CFG_BITS-1:0]   cfg_wdata;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [31:0]           s_tdata;   // coef_channel[5:0], coef_tap[9:6], value[25:10]
    logic                  s_tuser;   // mode
    logic                  m_tvalid;
    logic                  m_tready;
    logic [39:0]           m_tdata;   // out_value[15:0], out_channel[21:16], out_position[33:22]
    logic                  m_tlast;   // row_end
    logic                  m_tuser;   // saturated

    conv_scoreboard sb;
    bit             tx_calm;        // sender runs back to back in this phase
    bit             hold_request;   // asks the sink for one long hold-off
    int             items_sent;

    depthwise_conv1d u_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_addr  (cfg_addr),
        .i_cfg_wdata (cfg_wdata),
        .i_s_tvalid  (s_tvalid),
        .o_s_tready  (s_tready),
        .i_s_tdata   (s_tdata),
        .i_s_tuser   (s_tuser),
        .o_m_tvalid  (m_tvalid),
        .i_m_tready  (m_tready),
        .o_m_tdata   (m_tdata),
        .o_m_tlast   (m_tlast),
        .o_m_tuser   (m_tuser)
    );

    always begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Data values lean on the extremes so products saturate both ways; 0x4000 is a unit tap.
    function automatic logic [15:0] draw_word();
        case ($urandom_range(0, 7))
            0: return 16'h7FFF;
            1: return 16'h8000;
            2: return 16'h4000;
            3: return 16'($urandom_range(0, 31));
            4: return 16'hFFFF - 16'($urandom_range(0, 31));
            default: return 16'($urandom);
        endcase
    endfunction

    // Offer one item after a random gap; returns at the edge that accepts it.
    // tvalid stays high when the next call has no gap, so no drop-and-raise in one step.
    task automatic send_item(input logic mode, input logic [CH_BITS-1:0] cch,
                             input logic [TAP_BITS-1:0] ctap, input logic [15:0] val);
        int gap;
        gap = tx_calm ? 0 : $urandom_range(0, 10);
        @(negedge clk);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= mode;
        s_tdata  <= {6'd0, val, ctap, cch};
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        sb.note_item(mode, cch, ctap, val);
        items_sent++;
    endtask

    // coef fields are don't-care on samples, so they carry noise
    task automatic send_sample(input logic [15:0] val);
        send_item(MODE_SAMPLE, CH_BITS'($urandom), TAP_BITS'($urandom), val);
    endtask

    // Stop offering, let every pending result drain, then give the block time to finish
    // any sample that produces no result before the registers change.
    task automatic wait_idle();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (sb.awaited.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_A_BITS-1:0] idx, input int unsigned val);
        logic [CFG_BITS-1:0] word;
        word = CFG_BITS'(val);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= word;
        sb.set_reg(idx, word);
        @(negedge clk);
        cfg_we    <= 1'b0;
    endtask

    // One configuration: program it, make sure every tap in use is loaded, stream samples
    // with a few tap reloads mixed in, then complete the row so the next phase starts clean.
    task automatic run_phase(input int unsigned nch, input int unsigned k,
                             input int unsigned rw, input int unsigned sh, input int n);
        int unsigned junk, live_ch, live_k, c, t;
        int          j;
        wait_idle();
        // unused upper bits of the write word are don't-care; toggle them now and then
        junk = ($urandom_range(0, 3) == 0) ? $urandom : 0;
        write_reg(CFG_CHANNELS, nch | (junk << NCH_BITS));
        write_reg(CFG_KERNEL, k | (junk << K_BITS));
        write_reg(CFG_ROW, rw);
        write_reg(CFG_SHIFT, sh | (junk << SH_BITS));
        tx_calm = ($urandom_range(0, 3) == 0);
        live_ch = sb.live_channels();
        live_k  = sb.live_taps();
        for (c = 0; c < live_ch; c++)
            for (t = 0; t < live_k; t++)
                if (!sb.tap_loaded[c][t] || $urandom_range(0, 7) == 0)
                    send_item(MODE_LOAD, CH_BITS'(c), TAP_BITS'(t), draw_word());
        for (j = 0; j < n; j++) begin
            if ($urandom_range(0, 9) == 0)
                send_item(MODE_LOAD, CH_BITS'($urandom), TAP_BITS'($urandom), draw_word());
            else
                send_sample(draw_word());
        end
        while (sb.ch_cnt != 0 || sb.pos_cnt != 0) send_sample(draw_word());
    endtask

    // Result sink: random hold-off per item, calm stretches, and one long hold on request.
    initial begin : result_sink
        int gap;
        int seen;
        bit rx_calm;
        m_tready = 1'b0;
        seen     = 0;
        rx_calm  = 1'b0;
        wait (rst_n === 1'b1);
        forever begin
            @(negedge clk);
            if (hold_request) begin
                gap          = HOLD_CYCLES;
                hold_request = 1'b0;
            end else begin
                gap = rx_calm ? 0 : $urandom_range(0, 10);
            end
            if (gap > 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            m_tready <= 1'b1;
            @(posedge clk);
            while (!m_tvalid) @(posedge clk);
            sb.check_result(m_tdata[15:0], m_tdata[21:16], m_tdata[33:22], m_tlast, m_tuser);
            seen++;
            if (seen % 64 == 0) rx_calm = ($urandom_range(0, 3) == 0);
        end
    end

    // Watchdog: ends the run if no handshake of any kind happens for too long.
    initial begin : watchdog
        int quiet;
        quiet = 0;
        wait (rst_n === 1'b1);
        while (quiet < WATCHDOG_CYCLES) begin
            @(posedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we)
                quiet = 0;
            else
                quiet++;
        end
        $display("** depthwise_conv1d: FAILED **");
        $finish;
    end

    initial begin : stimulus
        int          budget_end;
        int unsigned nch, k, rw, sh, keff;
        bit          wide;
        sb           = new();
        rst_n        = 1'b0;
        cfg_we       = 1'b0;
        cfg_addr     = '0;
        cfg_wdata    = '0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        s_tuser      = MODE_LOAD;
        tx_calm      = 1'b0;
        hold_request = 1'b0;
        items_sent   = 0;
        repeat (8) @(negedge clk);
        rst_n <= 1'b1;

        // reset settings: one channel, one tap, one-position rows, shift 14;
        // a unit tap passes samples through, every result ends a row
        send_item(MODE_LOAD, 0, 0, 16'h4000);
        send_sample(16'h7FFF);
        send_sample(16'h8000);
        send_sample(16'h0001);
        send_sample(16'hFFFF);

        // no shift, full-scale taps and samples: saturates high and low
        wait_idle();
        write_reg(CFG_SHIFT, 0);
        write_reg(CFG_CHANNELS, 2);
        write_reg(CFG_KERNEL, 2);
        write_reg(CFG_ROW, 3);
        send_item(MODE_LOAD, 0, 0, 16'h7FFF);
        send_item(MODE_LOAD, 0, 1, 16'h8000);
        send_item(MODE_LOAD, 1, 0, 16'h8000);
        send_item(MODE_LOAD, 1, 1, 16'h8000);
        send_item(MODE_LOAD, 63, 15, 16'h4000);
        send_sample(16'h7FFF);
        send_sample(16'h8000);
        send_sample(16'h8000);
        send_sample(16'h8000);
        send_sample(16'h7FFF);
        send_sample(16'h7FFF);

        // shrink channels and row width mid-row: both counters end up past their limits
        wait_idle();
        write_reg(CFG_CHANNELS, 3);
        write_reg(CFG_KERNEL, 1);
        write_reg(CFG_ROW, 8);
        write_reg(CFG_SHIFT, 14);
        send_item(MODE_LOAD, 2, 0, 16'hC000);
        repeat (5) send_sample(draw_word());
        wait_idle();
        write_reg(CFG_CHANNELS, 1);
        write_reg(CFG_ROW, 1);
        repeat (2) send_sample(draw_word());

        // one result per sample while the sink holds off: the block fills and stalls input
        wait_idle();
        hold_request = 1'b1;
        run_phase(4, 1, 50, 14, 200);

        // register extremes and out-of-range writes
        run_phase(127, 2, 3, 0, 30);        // channels saturate to 64, no shift
        run_phase(2, 31, 20, 30, 40);       // kernel saturates to 16, largest shift
        run_phase(3, 10, 6, 14, 50);        // kernel wider than row: no results at all
        run_phase(0, 0, 0, 31, 100);        // zeros act as one, shift clips

        // random configurations, mostly small rows and few channels
        budget_end = items_sent + RANDOM_ITEMS;
        while (items_sent < budget_end) begin
            wide = ($urandom_range(0, 5) == 0);
            case ($urandom_range(0, 9))
                0:       k = 0;
                1:       k = $urandom_range(17, 31);
                default: k = wide ? $urandom_range(1, 3) : $urandom_range(1, 16);
            endcase
            if (wide) begin
                nch = $urandom_range(9, 127);
                if (k > 3) k = 3;
            end else begin
                nch = $urandom_range(0, 8);
            end
            keff = (k == 0) ? 1 : (k > MAX_TAPS) ? MAX_TAPS : k;
            if ($urandom_range(0, 9) == 0)
                rw = $urandom_range(0, keff - 1);
            else
                rw = keff + $urandom_range(0, wide ? 2 : 24);
            sh = $urandom_range(0, 1) ? $urandom_range(12, 16) : $urandom_range(0, 31);
            run_phase(nch, k, rw, sh, $urandom_range(20, 120));
        end

        wait_idle();
        if (sb.errors == 0) begin
            $display("** depthwise_conv1d: PASSED **");
        end else begin
            $display("** depthwise_conv1d: FAILED **");
        end
        $finish;
    end

endmodule

>>> filelist.f
hdl/dwc_pkg.sv
hdl/dwc_ctrl.sv
hdl/dwc_datapath.sv
hdl/depthwise_conv1d.sv
verif/tb_depthwise_conv1d.sv
